// ===== rtl/prr_pkg.sv =====
// prr_pkg: shared types and constants for the priority round-robin scheduler.
// No dependencies; every other file in rtl/ refers to it by scoped names.
package prr_pkg;

    localparam int MODE_W    = 3;
    localparam int TID_W     = 4;
    localparam int PRIO_W    = 2;
    localparam int FLAGS_W   = 2;
    localparam int MS_W      = 16;
    localparam int SLICE_W   = 8;
    localparam int TPS_W     = 10;
    localparam int SLEEP_W   = 16;
    localparam int TICK_W    = 32;
    localparam int PROD_W    = MS_W + TPS_W;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam logic [MODE_W-1:0] MODE_TICK      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SCHED     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CREATE    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SLEEP     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SET_STATE = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_SLICE_LENGTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_SEC = 2'd1;

    localparam logic [SLICE_W-1:0] SLICE_RESET   = 8'd5;
    localparam logic [TPS_W-1:0]   TPS_RESET     = 10'd100;
    localparam logic [TPS_W-1:0]   MS_PER_SECOND = 10'd1000;
    localparam logic [SLEEP_W-1:0] SLEEP_MAX     = 16'hFFFF;
    localparam logic [SLEEP_W-1:0] SLEEP_MIN     = 16'd1;
    localparam logic [FLAGS_W-1:0] FLAG_SLEEPING = 2'b01;

    typedef struct packed {
        logic                 valid;
        logic [PRIO_W-1:0]    prio;
        logic [FLAGS_W-1:0]   flags;
        logic [SLEEP_W-1:0]   sleep_left;
    } slot_t;

    typedef struct packed {
        logic clear;
        logic eval;
        logic commit;
    } pick_ctl_t;

endpackage

// ===== rtl/prr_if.sv =====
// prr_if: valid/ready channels of the scheduler (events, results, register writes).
// Depends on prr_pkg for field widths.
interface prr_evt_if;
    logic                          valid;
    logic                          ready;
    logic [prr_pkg::MODE_W-1:0]    mode;
    logic [prr_pkg::TID_W-1:0]     task_id;
    logic [prr_pkg::PRIO_W-1:0]    prio;
    logic [prr_pkg::FLAGS_W-1:0]   state_flags;
    logic [prr_pkg::MS_W-1:0]      sleep_ms;

    modport source (output valid, mode, task_id, prio, state_flags, sleep_ms, input ready);
    modport sink   (input valid, mode, task_id, prio, state_flags, sleep_ms, output ready);
endinterface

interface prr_res_if;
    logic                          valid;
    logic                          ready;
    logic [prr_pkg::TID_W-1:0]     running_task;
    logic                          switched;
    logic                          no_ready;

    modport source (output valid, running_task, switched, no_ready, input ready);
    modport sink   (input valid, running_task, switched, no_ready, output ready);
endinterface

interface prr_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [prr_pkg::CFG_IDX_W-1:0]   index;
    logic [prr_pkg::CFG_DAT_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/prr_slot_mem.sv =====
// prr_slot_mem: task slot table, one write and one registered read per cycle.
// Per-entry written bits make never-written slots read as all zero. Uses prr_pkg.
module prr_slot_mem #(
    parameter int NUM_TASKS = 16,
    localparam int AW = $clog2(NUM_TASKS)
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  prr_pkg::slot_t  wr_data,
    input  logic            rd_en,
    input  logic [AW-1:0]   rd_addr,
    output prr_pkg::slot_t  rd_data
);

    prr_pkg::slot_t         mem [NUM_TASKS];
    logic [NUM_TASKS-1:0]   written_reg;
    prr_pkg::slot_t         rd_data_reg;
    logic                   rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
            rd_vld_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                written_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= written_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

// ===== rtl/prr_sleep_conv.sv =====
// prr_sleep_conv: converts sleep milliseconds to ticks, ms * tps / 1000.
// One shared multiplier: ms * tps first, then a reciprocal multiply for the divide by 1000.
// Uses prr_pkg.
module prr_sleep_conv (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [prr_pkg::MS_W-1:0]      ms,
    input  logic [prr_pkg::TPS_W-1:0]     tps,
    output logic                          done,
    output logic [prr_pkg::SLEEP_W-1:0]   ticks
);

    localparam int PW = prr_pkg::PROD_W;
    localparam int MW = PW + 1;
    localparam int SH = 36;
    localparam int QW = 2 * MW - SH;

    localparam logic [MW-1:0] RECIP_MS = 27'd68719477;

    logic            step_reg;
    logic            done_reg;
    logic [PW-1:0]   prod_reg;
    logic [QW-1:0]   quot_reg;
    logic [MW-1:0]   mul_a;
    logic [MW-1:0]   mul_b;
    logic [2*MW-1:0] mul_p;

    assign mul_a = step_reg ? {1'b0, prod_reg} : MW'(ms);
    assign mul_b = step_reg ? RECIP_MS : MW'(tps);
    assign mul_p = mul_a * mul_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= start;
            done_reg <= step_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_reg <= mul_p[PW-1:0];
        end
        if (step_reg)
        begin
            quot_reg <= mul_p[2*MW-1:SH];
        end
    end

    assign done  = done_reg;
    assign ticks = (|quot_reg[QW-1:prr_pkg::SLEEP_W]) ? prr_pkg::SLEEP_MAX :
                   (quot_reg == '0)                   ? prr_pkg::SLEEP_MIN :
                                                        quot_reg[prr_pkg::SLEEP_W-1:0];

endmodule

// ===== rtl/prr_pick.sv =====
// prr_pick: per-priority round-robin pick over one sweep of the slot table.
// Holds the last pick of each priority; depends on prr_pkg.
module prr_pick #(
    parameter int NUM_TASKS = 16,
    parameter int NUM_PRIO  = 4,
    localparam int AW = $clog2(NUM_TASKS)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  prr_pkg::pick_ctl_t  ctl,
    input  prr_pkg::slot_t      slot,
    input  logic [AW-1:0]       slot_idx,
    output logic                found,
    output logic [AW-1:0]       idx
);

    logic [NUM_PRIO-1:0] aft_found_reg;
    logic [NUM_PRIO-1:0] wrp_found_reg;
    logic [AW-1:0]       aft_idx_reg [NUM_PRIO];
    logic [AW-1:0]       wrp_idx_reg [NUM_PRIO];
    logic [AW-1:0]       rr_reg      [NUM_PRIO];

    logic                slot_ready;
    logic [NUM_PRIO-1:0] cap_aft;
    logic [NUM_PRIO-1:0] cap_wrp;
    logic [NUM_PRIO-1:0] lane_found;
    logic [AW-1:0]       lane_idx [NUM_PRIO];
    logic [NUM_PRIO-1:0] win;
    logic                taken;

    always_comb
    begin
        slot_ready = ctl.eval && slot.valid && (slot.flags == '0);
        taken      = 1'b0;
        idx        = '0;
        for (int p = 0; p < NUM_PRIO; p++)
        begin
            cap_aft[p] = slot_ready && (int'(slot.prio) == p) && (slot_idx > rr_reg[p])
                         && !aft_found_reg[p];
            cap_wrp[p] = slot_ready && (int'(slot.prio) == p) && (slot_idx <= rr_reg[p])
                         && !wrp_found_reg[p];
            lane_found[p] = aft_found_reg[p] || wrp_found_reg[p];
            lane_idx[p]   = aft_found_reg[p] ? aft_idx_reg[p] : wrp_idx_reg[p];
            win[p]        = lane_found[p] && !taken;
            taken         = taken || lane_found[p];
            if (win[p])
            begin
                idx = lane_idx[p];
            end
        end
        found = taken;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            aft_found_reg <= '0;
            wrp_found_reg <= '0;
            for (int p = 0; p < NUM_PRIO; p++)
            begin
                rr_reg[p] <= '0;
            end
        end
        else
        begin
            if (ctl.clear)
            begin
                aft_found_reg <= '0;
                wrp_found_reg <= '0;
            end
            else
            begin
                aft_found_reg <= aft_found_reg | cap_aft;
                wrp_found_reg <= wrp_found_reg | cap_wrp;
            end
            if (ctl.commit)
            begin
                for (int p = 0; p < NUM_PRIO; p++)
                begin
                    if (win[p])
                    begin
                        rr_reg[p] <= lane_idx[p];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int p = 0; p < NUM_PRIO; p++)
        begin
            if (cap_aft[p])
            begin
                aft_idx_reg[p] <= slot_idx;
            end
            if (cap_wrp[p])
            begin
                wrp_idx_reg[p] <= slot_idx;
            end
        end
    end

endmodule

// ===== rtl/priority_round_robin_task_scheduler_core.sv =====
// Top level of the priority round-robin task scheduler: sequencer, registers, result buffer.
// Uses prr_pkg, prr_if, prr_slot_mem, prr_sleep_conv and prr_pick.
//
// Usage:
//   evt carries one event (tick, schedule, create, sleep current, set state); one result
//   per event leaves on res (running task, switched, no_ready). cfg writes slice_length
//   (index 0) and ticks_per_second (index 1); it is always ready and is meant to be
//   written only while the block is idle.
//   Events are processed one at a time. A tick sweeps the slot table once for the sleep
//   timers and, when the slice runs out, once more for the pick; a schedule sweeps it once
//   for the pick; a sleep first waits for the two multiply steps of the sleep conversion
//   and then sweeps the table for the pick. Each sweep reads one slot per cycle through
//   the one read port of the slot table, which also has one write port.
//   evt is ready only between events.
//   The result sits in an output register; the next event is accepted while it waits,
//   and a stalled res only holds that event in its last state until the register frees.
//   Reset clears all slots, the last picks, the current task and the tick count, and
//   loads slice_left and slice_length with 5 and ticks_per_second with 100.
module priority_round_robin_task_scheduler_core #(
    parameter int NUM_TASKS = 16,
    parameter int NUM_PRIO  = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    prr_evt_if.sink    evt,
    prr_res_if.source  res,
    prr_cfg_if.sink    cfg
);

    localparam int AW   = $clog2(NUM_TASKS);
    localparam int CW   = $clog2(NUM_TASKS + 1);
    localparam int ST_W = 3;

    localparam logic [ST_W-1:0] S_IDLE   = 3'd0;
    localparam logic [ST_W-1:0] S_EXEC   = 3'd1;
    localparam logic [ST_W-1:0] S_TICK   = 3'd2;
    localparam logic [ST_W-1:0] S_SCAN   = 3'd3;
    localparam logic [ST_W-1:0] S_COMMIT = 3'd4;
    localparam logic [ST_W-1:0] S_CONV   = 3'd5;
    localparam logic [ST_W-1:0] S_SET    = 3'd6;
    localparam logic [ST_W-1:0] S_DONE   = 3'd7;

    logic [ST_W-1:0]                   state_reg, state_next;
    logic [prr_pkg::MODE_W-1:0]        mode_reg;
    logic [prr_pkg::TID_W-1:0]         tid_reg;
    logic [prr_pkg::PRIO_W-1:0]        prio_reg;
    logic [prr_pkg::FLAGS_W-1:0]       flags_reg;
    logic [prr_pkg::MS_W-1:0]          ms_reg;
    logic [prr_pkg::SLICE_W-1:0]       slice_len_reg;
    logic [prr_pkg::TPS_W-1:0]         tps_reg;
    logic [prr_pkg::SLICE_W-1:0]       slice_left_reg, slice_left_next;
    logic [prr_pkg::TICK_W-1:0]        tick_count_reg, tick_count_next;
    logic [AW-1:0]                     current_reg, current_next;
    logic                              sched_reg, sched_next;
    logic                              none_reg, none_next;
    logic [CW-1:0]                     iss_reg, iss_next;
    logic                              proc_vld_reg, proc_vld_next;
    logic [AW-1:0]                     proc_idx_reg, proc_idx_next;
    logic                              res_vld_reg, res_vld_next;
    logic [prr_pkg::TID_W-1:0]         res_task_reg;
    logic                              res_sw_reg;
    logic                              res_none_reg;

    logic                              evt_ready;
    logic                              res_load;
    logic                              tid_ok;
    logic [AW-1:0]                     tid_addr;
    logic [prr_pkg::PRIO_W-1:0]        prio_clamp;
    logic [prr_pkg::SLICE_W-1:0]       slice_dec;

    logic                              mem_wr_en;
    logic [AW-1:0]                     mem_wr_addr;
    prr_pkg::slot_t                    mem_wr_data;
    logic                              mem_rd_en;
    logic [AW-1:0]                     mem_rd_addr;
    prr_pkg::slot_t                    mem_rd_data;

    logic                              conv_start;
    logic                              conv_done;
    logic [prr_pkg::SLEEP_W-1:0]       conv_ticks;

    prr_pkg::pick_ctl_t                pick_ctl;
    logic                              pick_found;
    logic [AW-1:0]                     pick_idx;

    prr_slot_mem #(
        .NUM_TASKS (NUM_TASKS)
    ) u_slot_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    prr_sleep_conv u_sleep_conv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (conv_start),
        .ms    (ms_reg),
        .tps   (tps_reg),
        .done  (conv_done),
        .ticks (conv_ticks)
    );

    prr_pick #(
        .NUM_TASKS (NUM_TASKS),
        .NUM_PRIO  (NUM_PRIO)
    ) u_pick (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (pick_ctl),
        .slot     (mem_rd_data),
        .slot_idx (proc_idx_reg),
        .found    (pick_found),
        .idx      (pick_idx)
    );

    assign evt_ready  = (state_reg == S_IDLE);
    assign evt.ready  = evt_ready;
    assign cfg.ready  = 1'b1;
    assign tid_ok     = int'(tid_reg) < NUM_TASKS;
    assign tid_addr   = AW'(tid_reg);
    assign prio_clamp = (int'(prio_reg) >= NUM_PRIO) ? prr_pkg::PRIO_W'(NUM_PRIO - 1) : prio_reg;
    assign slice_dec  = (slice_left_reg != '0) ? slice_left_reg - 1'b1 : slice_left_reg;

    always_comb
    begin
        state_next      = state_reg;
        slice_left_next = slice_left_reg;
        tick_count_next = tick_count_reg;
        current_next    = current_reg;
        sched_next      = sched_reg;
        none_next       = none_reg;
        iss_next        = iss_reg;
        proc_vld_next   = 1'b0;
        proc_idx_next   = iss_reg[AW-1:0];
        res_load        = 1'b0;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = proc_idx_reg;
        mem_wr_data     = mem_rd_data;
        mem_rd_en       = 1'b0;
        mem_rd_addr     = iss_reg[AW-1:0];
        conv_start      = 1'b0;
        pick_ctl        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (evt.valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                sched_next = 1'b0;
                none_next  = 1'b0;
                iss_next   = '0;
                unique case (mode_reg)
                    prr_pkg::MODE_TICK:
                    begin
                        tick_count_next = tick_count_reg + 1'b1;
                        if (slice_dec == '0)
                        begin
                            slice_left_next = slice_len_reg;
                            sched_next      = 1'b1;
                        end
                        else
                        begin
                            slice_left_next = slice_dec;
                        end
                        state_next = S_TICK;
                    end
                    prr_pkg::MODE_SCHED:
                    begin
                        sched_next     = 1'b1;
                        pick_ctl.clear = 1'b1;
                        state_next     = S_SCAN;
                    end
                    prr_pkg::MODE_CREATE:
                    begin
                        if (tid_ok)
                        begin
                            mem_wr_en              = 1'b1;
                            mem_wr_addr            = tid_addr;
                            mem_wr_data.valid      = 1'b1;
                            mem_wr_data.prio       = prio_clamp;
                            mem_wr_data.flags      = '0;
                            mem_wr_data.sleep_left = '0;
                        end
                        state_next = S_DONE;
                    end
                    prr_pkg::MODE_SLEEP:
                    begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = current_reg;
                        conv_start  = 1'b1;
                        state_next  = S_CONV;
                    end
                    prr_pkg::MODE_SET_STATE:
                    begin
                        if (tid_ok)
                        begin
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = tid_addr;
                            state_next  = S_SET;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_TICK:
            begin
                if (iss_reg != CW'(NUM_TASKS))
                begin
                    mem_rd_en     = 1'b1;
                    iss_next      = iss_reg + 1'b1;
                    proc_vld_next = 1'b1;
                end
                if (proc_vld_reg && (mem_rd_data.sleep_left != '0))
                begin
                    mem_wr_en              = 1'b1;
                    mem_wr_data.sleep_left = mem_rd_data.sleep_left - 1'b1;
                    if (mem_rd_data.sleep_left == prr_pkg::SLEEP_MIN)
                    begin
                        mem_wr_data.flags = mem_rd_data.flags & ~prr_pkg::FLAG_SLEEPING;
                    end
                end
                if (iss_reg == CW'(NUM_TASKS))
                begin
                    iss_next = '0;
                    if (sched_reg)
                    begin
                        pick_ctl.clear = 1'b1;
                        state_next     = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_SCAN:
            begin
                if (iss_reg != CW'(NUM_TASKS))
                begin
                    mem_rd_en     = 1'b1;
                    iss_next      = iss_reg + 1'b1;
                    proc_vld_next = 1'b1;
                end
                pick_ctl.eval = proc_vld_reg;
                if (iss_reg == CW'(NUM_TASKS))
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                pick_ctl.commit = 1'b1;
                if (pick_found)
                begin
                    current_next = pick_idx;
                end
                none_next  = !pick_found;
                state_next = S_DONE;
            end
            S_CONV:
            begin
                if (conv_done)
                begin
                    mem_wr_en              = 1'b1;
                    mem_wr_addr            = current_reg;
                    mem_wr_data.flags      = mem_rd_data.flags | prr_pkg::FLAG_SLEEPING;
                    mem_wr_data.sleep_left = conv_ticks;
                    sched_next             = 1'b1;
                    iss_next               = '0;
                    pick_ctl.clear         = 1'b1;
                    state_next             = S_SCAN;
                end
            end
            S_SET:
            begin
                mem_wr_en         = 1'b1;
                mem_wr_addr       = tid_addr;
                mem_wr_data.flags = flags_reg;
                state_next        = S_DONE;
            end
            S_DONE:
            begin
                if (!res_vld_reg || res.ready)
                begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        res_vld_next = res_load ? 1'b1 : (res.ready ? 1'b0 : res_vld_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            slice_len_reg  <= prr_pkg::SLICE_RESET;
            tps_reg        <= prr_pkg::TPS_RESET;
            slice_left_reg <= prr_pkg::SLICE_RESET;
            tick_count_reg <= '0;
            current_reg    <= '0;
            sched_reg      <= 1'b0;
            none_reg       <= 1'b0;
            iss_reg        <= '0;
            proc_vld_reg   <= 1'b0;
            res_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            slice_left_reg <= slice_left_next;
            tick_count_reg <= tick_count_next;
            current_reg    <= current_next;
            sched_reg      <= sched_next;
            none_reg       <= none_next;
            iss_reg        <= iss_next;
            proc_vld_reg   <= proc_vld_next;
            res_vld_reg    <= res_vld_next;
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    prr_pkg::REG_SLICE_LENGTH:  slice_len_reg <= cfg.data[prr_pkg::SLICE_W-1:0];
                    prr_pkg::REG_TICKS_PER_SEC: tps_reg       <= cfg.data[prr_pkg::TPS_W-1:0];
                    default:                    ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        proc_idx_reg <= proc_idx_next;
        if (evt.valid && evt_ready)
        begin
            mode_reg  <= evt.mode;
            tid_reg   <= evt.task_id;
            prio_reg  <= evt.prio;
            flags_reg <= evt.state_flags;
            ms_reg    <= evt.sleep_ms;
        end
        if (res_load)
        begin
            res_task_reg <= prr_pkg::TID_W'(current_reg);
            res_sw_reg   <= sched_reg;
            res_none_reg <= none_reg;
        end
    end

    assign res.valid        = res_vld_reg;
    assign res.running_task = res_task_reg;
    assign res.switched     = res_sw_reg;
    assign res.no_ready     = res_none_reg;

    a_none_needs_sched: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (res.switched || !res.no_ready))
        else $error("no_ready without a scheduling decision");

    a_current_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        int'(current_reg) < NUM_TASKS)
        else $error("current task outside the slot table");

    a_no_pick_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COMMIT && !pick_found) |=> $stable(current_reg))
        else $error("current task changed without a ready task");

    a_conv_while_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        conv_done |-> (state_reg == S_CONV))
        else $error("sleep conversion finished outside its wait state");

endmodule
